### rtl/sgm_pcs_pkg.sv
`default_nettype none

package sgm_pcs_pkg;

    // Field widths fixed by the interface.
    localparam int DISP_W     = 7;
    localparam int COST_IN_W  = 16;
    localparam int INT_W      = 8;
    localparam int NEAR_W     = 10;
    localparam int FAR_W      = 16;
    localparam int DCNT_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(FAR_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_PENALTY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_NUMERATOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPARITY_COUNT = 2'd2;

    // Register values after reset.
    localparam logic [NEAR_W-1:0] NEAR_RESET = 10'd30;
    localparam logic [FAR_W-1:0]  FAR_RESET  = 16'd38250;
    localparam logic [DCNT_W-1:0] DCNT_RESET = 8'd64;

    typedef struct packed {
        logic             start;
        logic [FAR_W-1:0] num;
        logic [INT_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [FAR_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

### rtl/sgm_pcs_div.sv
`default_nettype none

module sgm_pcs_div
    import sgm_pcs_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FAR_W-1:0]     r_quo;
    logic [INT_W-1:0]     r_rem;
    logic [INT_W-1:0]     r_den;

    logic [INT_W:0]   trial;
    logic             ge;
    logic [INT_W-1:0] n_rem;

    // Restoring division: the numerator shifts out of the top of the quotient
    // register while quotient bits enter at the bottom, one bit per cycle.
    always_comb begin
        trial = {r_rem, r_quo[FAR_W-1]};
        ge    = trial >= {1'b0, r_den};
        if (ge) begin
            n_rem = INT_W'(trial - {1'b0, r_den});
        end else begin
            n_rem = trial[INT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(FAR_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= {r_quo[FAR_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

### rtl/sgm_pcs_row_mem.sv
`default_nettype none

module sgm_pcs_row_mem #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 7
) (
    input  wire               i_clk,
    input  wire               i_we,
    input  wire  [ADDR_W-1:0] i_waddr,
    input  wire  [DATA_W-1:0] i_wdata,
    input  wire               i_re,
    input  wire  [ADDR_W-1:0] i_raddr0,
    input  wire  [ADDR_W-1:0] i_raddr1,
    output logic [DATA_W-1:0] o_rdata0,
    output logic [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data is registered and held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

`default_nettype wire

### rtl/sgm_path_cost_step.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    path_start, disparity_index,
//                                                 matching_cost, intensity
// out       output     o_out_valid / i_out_stall  path_cost, result_disparity,
//                                                 pixel_done
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Costs stream at one a cycle unless the divider or an output stall holds the
// compute stage. A disparity 0 item with a changed intensity holds the compute
// stage while the bit-serial divider forms the jump penalty.
// The previous row lives in a two-read, one-write memory; a write in the cycle
// of a read to the same entry is forwarded.
// Reset is synchronous and clears control state and registers; the row memory
// is not cleared. An output stall holds the compute stage and then the input.

module sgm_path_cost_step
    import sgm_pcs_pkg::*;
#(
    parameter int MAX_DISPARITY = 128,
    parameter int COST_BITS     = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire                   i_path_start,
    input  wire  [DISP_W-1:0]     i_disparity_index,
    input  wire  [COST_IN_W-1:0]  i_matching_cost,
    input  wire  [INT_W-1:0]      i_intensity,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [COST_IN_W-1:0]  o_path_cost,
    output logic [DISP_W-1:0]     o_result_disparity,
    output logic                  o_pixel_done
);

    localparam int AW    = (MAX_DISPARITY > 1) ? $clog2(MAX_DISPARITY) : 1;
    localparam int CNT_W = $clog2(MAX_DISPARITY + 1);
    localparam int CMP_W = (CNT_W > DCNT_W) ? CNT_W : DCNT_W;
    localparam int CIN_W = (COST_BITS > COST_IN_W) ? COST_BITS : COST_IN_W;
    localparam int SW    = CIN_W + 1;
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    // Configuration registers.
    logic [NEAR_W-1:0] r_near;
    logic [FAR_W-1:0]  r_far;
    logic [DCNT_W-1:0] r_dcount;

    // Path state.
    logic [COST_BITS-1:0] r_prev_min;
    logic [COST_BITS-1:0] r_run_min;
    logic [INT_W-1:0]     r_prev_int;
    logic [COST_BITS-1:0] r_held;
    logic [COST_BITS-1:0] r_jump;
    logic                 r_first;

    // Compute stage.
    logic                 r_b_valid;
    logic                 r_b_start;
    logic [DISP_W-1:0]    r_b_d;
    logic [COST_BITS-1:0] r_b_cost;
    logic                 r_b_oor;
    logic                 r_b_d0;
    logic                 r_b_right;
    logic                 r_b_last;
    logic                 r_b_dz;
    logic                 r_fwd0;
    logic                 r_fwd1;
    logic [COST_BITS-1:0] r_fwd_data;

    // Output register.
    logic                 r_out_valid;
    logic [COST_IN_W-1:0] r_out_cost;
    logic [DISP_W-1:0]    r_out_d;
    logic                 r_out_done;

    logic [CMP_W-1:0]     n_use;
    logic [CMP_W-1:0]     d_ext;
    logic [CMP_W-1:0]     d_inc;
    logic                 in_acc;
    logic                 in_range;
    logic                 is_d0;
    logic [INT_W-1:0]     delta;
    logic [CIN_W-1:0]     cost_ext;
    logic [COST_BITS-1:0] cost_in;
    logic [AW-1:0]        raddr0;
    logic [AW-1:0]        raddr1;
    logic [AW-1:0]        waddr;
    logic                 mem_we;
    logic [COST_BITS-1:0] rdata0;
    logic [COST_BITS-1:0] rdata1;
    logic                 b_done;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    logic [COST_BITS-1:0] prev_d;
    logic [COST_BITS-1:0] prev_d1;
    logic                 first_eff;
    logic [COST_BITS-1:0] pmin_eff;
    logic [COST_BITS-1:0] run_eff;
    logic [COST_BITS-1:0] jp_eff;
    logic [COST_BITS-1:0] jump_new;
    logic [COST_BITS-1:0] lr;
    logic [CIN_W-1:0]     lr_w;

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= NEAR_RESET;
            r_far    <= FAR_RESET;
            r_dcount <= DCNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEAR_PENALTY:    r_near   <= i_cfg_data[NEAR_W-1:0];
                CFG_FAR_NUMERATOR:   r_far    <= i_cfg_data[FAR_W-1:0];
                CFG_DISPARITY_COUNT: r_dcount <= i_cfg_data[DCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Disparities in use: a count of zero acts as one, and the count is capped
    // at the row depth.
    always_comb begin
        if (r_dcount == '0) begin
            n_use = CMP_W'(1);
        end else if (CMP_W'(r_dcount) > CMP_W'(MAX_DISPARITY)) begin
            n_use = CMP_W'(MAX_DISPARITY);
        end else begin
            n_use = CMP_W'(r_dcount);
        end
    end

    assign d_ext    = CMP_W'(i_disparity_index);
    assign d_inc    = d_ext + CMP_W'(1);
    assign in_range = d_ext < n_use;
    assign is_d0    = i_disparity_index == '0;
    assign delta    = (i_intensity > r_prev_int) ? (i_intensity - r_prev_int)
                                                 : (r_prev_int - i_intensity);
    assign cost_ext = CIN_W'(i_matching_cost);
    assign cost_in  = (cost_ext > CIN_W'(COST_MAX)) ? COST_MAX : COST_BITS'(cost_ext);

    assign b_done     = r_b_valid && !div_rsp.busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_b_valid && !b_done;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign div_req.start = in_acc && in_range && is_d0 && (delta != '0);
    assign div_req.num   = r_far;
    assign div_req.den   = delta;

    sgm_pcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign raddr0 = AW'(i_disparity_index);
    assign raddr1 = AW'(d_inc);
    assign waddr  = AW'(r_b_d);
    assign mem_we = b_done && !r_b_oor;

    sgm_pcs_row_mem #(
        .DEPTH  (MAX_DISPARITY),
        .DATA_W (COST_BITS),
        .ADDR_W (AW)
    ) u_row_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (waddr),
        .i_wdata  (lr),
        .i_re     (in_acc),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    // Jump penalty for a new pixel: equal intensities give the maximum cost,
    // and the penalty never falls below the near penalty.
    always_comb begin
        logic [CIN_W-1:0] far_ext;
        logic [CIN_W-1:0] near_ext;
        far_ext  = r_b_dz ? CIN_W'(COST_MAX) : CIN_W'(div_rsp.quo);
        near_ext = CIN_W'(r_near);
        if (far_ext < near_ext) begin
            far_ext = near_ext;
        end
        jump_new = (far_ext > CIN_W'(COST_MAX)) ? COST_MAX : COST_BITS'(far_ext);
    end

    assign prev_d    = r_fwd0 ? r_fwd_data : rdata0;
    assign prev_d1   = r_fwd1 ? r_fwd_data : rdata1;
    assign first_eff = r_b_d0 ? r_b_start : r_first;
    assign pmin_eff  = r_b_d0 ? r_run_min : r_prev_min;
    assign run_eff   = r_b_d0 ? COST_MAX : r_run_min;
    assign jp_eff    = r_b_d0 ? jump_new : r_jump;

    always_comb begin
        logic [SW-1:0] best;
        logic [SW-1:0] c_left;
        logic [SW-1:0] c_right;
        logic [SW-1:0] c_jump;
        logic [SW-1:0] diff;
        logic [SW-1:0] sum;
        c_left  = SW'(r_held) + SW'(r_near);
        c_right = SW'(prev_d1) + SW'(r_near);
        c_jump  = SW'(pmin_eff) + SW'(jp_eff);
        best    = SW'(prev_d);
        if (!r_b_d0 && (c_left < best)) begin
            best = c_left;
        end
        if (r_b_right && (c_right < best)) begin
            best = c_right;
        end
        if (c_jump < best) begin
            best = c_jump;
        end
        // A candidate below the old minimum only arises from disordered input.
        diff = (best >= SW'(pmin_eff)) ? (best - SW'(pmin_eff)) : '0;
        sum  = SW'(r_b_cost) + diff;
        if (first_eff) begin
            lr = r_b_cost;
        end else if (sum > SW'(COST_MAX)) begin
            lr = COST_MAX;
        end else begin
            lr = COST_BITS'(sum);
        end
    end

    assign lr_w = CIN_W'(lr);

    // Compute stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_acc) begin
            r_b_valid <= 1'b1;
        end else if (b_done) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd0 <= 1'b0;
            r_fwd1 <= 1'b0;
        end else if (in_acc) begin
            r_fwd0 <= mem_we && (waddr == raddr0);
            r_fwd1 <= mem_we && (waddr == raddr1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_start  <= i_path_start;
            r_b_d      <= i_disparity_index;
            r_b_cost   <= cost_in;
            r_b_oor    <= !in_range;
            r_b_d0     <= is_d0;
            r_b_right  <= d_inc < n_use;
            r_b_last   <= d_inc == n_use;
            r_b_dz     <= delta == '0;
            r_fwd_data <= lr;
        end
    end

    // Path state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_min <= '0;
            r_run_min  <= COST_MAX;
            r_prev_int <= '0;
            r_held     <= COST_MAX;
            r_jump     <= COST_MAX;
            r_first    <= 1'b1;
        end else begin
            if (in_acc && in_range && is_d0) begin
                r_prev_int <= i_intensity;
            end
            if (mem_we) begin
                r_held    <= prev_d;
                r_run_min <= (lr < run_eff) ? lr : run_eff;
                if (r_b_d0) begin
                    r_first    <= r_b_start;
                    r_prev_min <= r_run_min;
                    r_jump     <= jump_new;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_done) begin
            r_out_cost <= r_b_oor ? '0 : lr_w[COST_IN_W-1:0];
            r_out_d    <= r_b_d;
            r_out_done <= !r_b_oor && r_b_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_path_cost        = r_out_cost;
    assign o_result_disparity = r_out_d;
    assign o_pixel_done       = r_out_done;

    a_div_only_pixel_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> (r_b_valid && r_b_d0))
        else $error("divider busy without a pixel start in the compute stage");

    a_run_min_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && !r_b_d0) |=> (r_run_min <= $past(r_run_min)))
        else $error("running minimum rose within a pixel");

    a_full_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_b_valid) |-> o_in_stall)
        else $error("item taken while compute stage and output are both full");

    a_forward_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && mem_we && (waddr == raddr0)) |=> (r_fwd0 && r_fwd_data == $past(lr)))
        else $error("write to the entry being read was not forwarded");

endmodule

`default_nettype wire

### dv/sgm_path_cost_step_checker.sv
`timescale 1ns / 1ps

module sgm_path_cost_step_checker
    import sgm_pcs_pkg::*;
#(
    parameter int MAX_DISPARITY = 128
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                   i_in_valid,
    input  wire                   i_in_stall,
    input  wire                   i_path_start,
    input  wire  [DISP_W-1:0]     i_disparity_index,
    input  wire  [COST_IN_W-1:0]  i_matching_cost,
    input  wire  [INT_W-1:0]      i_intensity,
    input  wire                   i_out_valid,
    input  wire                   i_out_stall,
    input  wire  [COST_IN_W-1:0]  i_path_cost,
    input  wire  [DISP_W-1:0]     i_result_disparity,
    input  wire                   i_pixel_done,
    output int                    o_error_count,
    output int                    o_pending
);

    localparam int unsigned COST_MAX = (1 << COST_IN_W) - 1;
    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic [COST_IN_W-1:0] path_cost;
        logic [DISP_W-1:0]    disparity;
        logic                 pixel_done;
    } t_path_result;

    t_path_result expected_path_costs[$];
    int mismatch_count = 0;

    // Register copies.
    int unsigned near_penalty;
    int unsigned far_numerator;
    int unsigned disparity_count;

    // Aggregation state carried from one item to the next.
    int unsigned prev_row [MAX_DISPARITY];
    int unsigned prev_minimum;
    int unsigned running_minimum;
    int unsigned prev_intensity;
    int unsigned held_left_cost;
    int unsigned jump_penalty;
    bit          first_pixel;

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: path cost mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic t_path_result aggregate_path_cost(
        input logic                 start,
        input logic [DISP_W-1:0]    disp,
        input logic [COST_IN_W-1:0] cost,
        input logic [INT_W-1:0]     pix
    );
        t_path_result res;
        int unsigned d, n, delta, far, best, cand, lr, pix_u;
        d = 32'(disp);
        pix_u = 32'(pix);
        n = disparity_count;
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_DISPARITY) begin
            n = MAX_DISPARITY;
        end
        res.path_cost = '0;
        res.disparity = disp;
        res.pixel_done = 1'b0;
        // Items beyond the disparities in use leave the state alone.
        if (d >= n) begin
            return res;
        end
        if (d == 0) begin
            delta = (pix_u > prev_intensity) ? pix_u - prev_intensity
                                             : prev_intensity - pix_u;
            far = (delta == 0) ? COST_MAX : far_numerator / delta;
            if (far < near_penalty) begin
                far = near_penalty;
            end
            jump_penalty = (far > COST_MAX) ? COST_MAX : far;
            first_pixel = start;
            prev_minimum = running_minimum;
            running_minimum = COST_MAX;
            prev_intensity = pix_u;
            held_left_cost = COST_MAX;
        end
        if (first_pixel) begin
            lr = 32'(cost);
        end else begin
            best = prev_row[d];
            if (d > 0) begin
                cand = held_left_cost + near_penalty;
                if (cand < best) best = cand;
            end
            if (d + 1 < n) begin
                cand = prev_row[d + 1] + near_penalty;
                if (cand < best) best = cand;
            end
            cand = prev_minimum + jump_penalty;
            if (cand < best) best = cand;
            // Disordered input can leave the best candidate under the old minimum.
            lr = (best >= prev_minimum) ? 32'(cost) + (best - prev_minimum) : 32'(cost);
            if (lr > COST_MAX) lr = COST_MAX;
        end
        // The left neighbour is the old row value of the last disparity handled.
        held_left_cost = prev_row[d];
        prev_row[d] = lr;
        if (lr < running_minimum) running_minimum = lr;
        res.path_cost = lr[COST_IN_W-1:0];
        res.pixel_done = (d + 1 == n);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_path_result want;
        if (!i_rst_n) begin
            near_penalty = 32'(NEAR_RESET);
            far_numerator = 32'(FAR_RESET);
            disparity_count = 32'(DCNT_RESET);
            prev_minimum = 0;
            running_minimum = COST_MAX;
            prev_intensity = 0;
            held_left_cost = COST_MAX;
            jump_penalty = COST_MAX;
            first_pixel = 1'b1;
            expected_path_costs.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NEAR_PENALTY:    near_penalty = 32'(i_cfg_data[NEAR_W-1:0]);
                    CFG_FAR_NUMERATOR:   far_numerator = 32'(i_cfg_data[FAR_W-1:0]);
                    CFG_DISPARITY_COUNT: disparity_count = 32'(i_cfg_data[DCNT_W-1:0]);
                    default: ;
                endcase
            end
            // Results are retired before new items are queued, so a result can
            // never be matched against an item accepted at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_path_costs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, disparity %0d cost %0d",
                                              i_result_disparity, i_path_cost));
                end else begin
                    want = expected_path_costs.pop_front();
                    if (i_path_cost !== want.path_cost) begin
                        report_mismatch($sformatf("disparity %0d: path_cost %0d, expected %0d",
                                                  want.disparity, i_path_cost, want.path_cost));
                    end
                    if (i_result_disparity !== want.disparity) begin
                        report_mismatch($sformatf("result_disparity %0d, expected %0d",
                                                  i_result_disparity, want.disparity));
                    end
                    if (i_pixel_done !== want.pixel_done) begin
                        report_mismatch($sformatf("disparity %0d: pixel_done %0b, expected %0b",
                                                  want.disparity, i_pixel_done,
                                                  want.pixel_done));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_path_costs.push_back(aggregate_path_cost(
                    i_path_start, i_disparity_index, i_matching_cost, i_intensity));
            end
            o_pending <= expected_path_costs.size();
        end
        o_error_count <= mismatch_count;
    end

endmodule

### dv/sgm_path_cost_step_tb.sv
`timescale 1ns / 1ps

module sgm_path_cost_step_tb
    import sgm_pcs_pkg::*;
();

    localparam int HALF_PERIOD_NS   = 5;
    localparam int RESET_CYCLES     = 6;
    localparam int MAX_DISPARITY    = 128;
    localparam int ITEM_TARGET      = 1050;
    localparam int PHASE_ITEMS      = 80;
    localparam int SETTLE_CYCLES    = 24;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  path_start = 1'b0;
    logic [DISP_W-1:0]     disparity_index = '0;
    logic [COST_IN_W-1:0]  matching_cost = '0;
    logic [INT_W-1:0]      intensity = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COST_IN_W-1:0]  path_cost;
    logic [DISP_W-1:0]     result_disparity;
    logic                  pixel_done;

    int error_count;
    int results_pending;

    // Stimulus bookkeeping.
    int sent_in_range = 0;
    int rows_written = 0;
    int disparities = int'(DCNT_RESET);
    int last_intensity = 0;
    int sender_idle_pct = 0;
    int stall_pct = 25;
    bit long_hold_pending = 1'b0;
    int idle_cycles = 0;

    always #HALF_PERIOD_NS clk = ~clk;

    sgm_path_cost_step #(
        .MAX_DISPARITY (MAX_DISPARITY)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_path_start       (path_start),
        .i_disparity_index  (disparity_index),
        .i_matching_cost    (matching_cost),
        .i_intensity        (intensity),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_path_cost        (path_cost),
        .o_result_disparity (result_disparity),
        .o_pixel_done       (pixel_done)
    );

    sgm_path_cost_step_checker #(
        .MAX_DISPARITY (MAX_DISPARITY)
    ) u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_path_start       (path_start),
        .i_disparity_index  (disparity_index),
        .i_matching_cost    (matching_cost),
        .i_intensity        (intensity),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_path_cost        (path_cost),
        .i_result_disparity (result_disparity),
        .i_pixel_done       (pixel_done),
        .o_error_count      (error_count),
        .o_pending          (results_pending)
    );

    function automatic int pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 0;
        if (r < 8) return (1 << COST_IN_W) - 1;
        if (r < 18) return $urandom_range(60000, 65535);
        return $urandom_range(0, 3000);
    endfunction

    function automatic int pick_intensity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return last_intensity;
        if (r < 40) return 0;
        if (r < 50) return 255;
        return $urandom_range(0, 255);
    endfunction

    // Offers one item after a random gap and returns at the edge that takes it.
    task automatic send_cost(input logic start, input int d, input int cost, input int pix);
        int gap, r;
        gap = 0;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            r = $urandom_range(0, 99);
            if (r < 80) gap = $urandom_range(1, 3);
            else if (r < 95) gap = $urandom_range(4, 12);
            else gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        path_start <= start;
        disparity_index <= d[DISP_W-1:0];
        matching_cost <= cost[COST_IN_W-1:0];
        intensity <= pix[INT_W-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (d < disparities) sent_in_range++;
        last_intensity = pix;
    endtask

    task automatic drain_results(input bit settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] near_data,
                             input logic [CFG_DATA_W-1:0] far_data,
                             input logic [CFG_DATA_W-1:0] count_data,
                             input bit touch_spare);
        int n;
        drain_results(1'b1);
        if (touch_spare) write_register(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
        write_register(CFG_NEAR_PENALTY, near_data);
        write_register(CFG_FAR_NUMERATOR, far_data);
        write_register(CFG_DISPARITY_COUNT, count_data);
        cfg_we <= 1'b0;
        n = int'(count_data[DCNT_W-1:0]);
        if (n == 0) n = 1;
        else if (n > MAX_DISPARITY) n = MAX_DISPARITY;
        disparities = n;
    endtask

    task automatic send_pixel_clean(input logic start, input int pix);
        for (int d = 0; d < disparities; d++) begin
            send_cost(start, d, pick_cost(), pix);
        end
    endtask

    // Skipped, repeated, disordered and out-of-range disparities.
    task automatic send_pixel_broken();
        int len, d, pix;
        len = $urandom_range(1, disparities + 2);
        pix = pick_intensity();
        d = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, 127);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 4) == 0) pix = pick_intensity();
            send_cost($urandom_range(0, 1) == 1, d, pick_cost(), pix);
            case ($urandom_range(0, 3))
                0: d = $urandom_range(0, 127);
                1: d = d + $urandom_range(2, 3);
                default: d = d + 1;
            endcase
            if (d > 127) d = $urandom_range(0, 127);
        end
    endtask

    task automatic run_phase(input int budget);
        int goal;
        goal = sent_in_range + budget;
        while (sent_in_range < goal) begin
            // Row entries beyond those written so far must be filled by a path's
            // first pixel before any later pixel reads them.
            if (disparities > rows_written) begin
                send_pixel_clean(1'b1, pick_intensity());
                rows_written = disparities;
            end else if ($urandom_range(0, 3) == 0) begin
                send_pixel_broken();
            end else begin
                send_pixel_clean($urandom_range(0, 6) == 0, pick_intensity());
            end
            if ($urandom_range(0, 19) == 0) drain_results(1'b0);
        end
    endtask

    // Receiver: random stall runs, and one long hold-off when asked for.
    initial begin : receiver
        int run_left, r;
        bit hold_now;
        run_left = 0;
        hold_now = 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                out_stall <= 1'b0;
            end else if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    hold_now = $urandom_range(0, 99) < stall_pct;
                    r = $urandom_range(0, 99);
                    if (!hold_now) run_left = $urandom_range(1, 12);
                    else if (r < 85) run_left = $urandom_range(1, 3);
                    else if (r < 97) run_left = $urandom_range(4, 12);
                    else run_left = $urandom_range(15, 40);
                end
                run_left--;
                out_stall <= hold_now;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        @(posedge clk);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("sgm_path_cost_step_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int phase;
        logic [CFG_DATA_W-1:0] near_data, far_data, count_data;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items on four disparities.
        configure(CFG_DATA_W'(NEAR_RESET), FAR_RESET, 16'd4, 1'b0);
        // Path start at equal intensity; the start flag on disparity 2 is ignored.
        send_cost(1'b1, 0, 0, 0);
        send_cost(1'b0, 1, 65535, 0);
        send_cost(1'b1, 2, 1, 0);
        send_cost(1'b0, 3, 255, 0);
        rows_written = 4;
        // Largest intensity step with saturating costs.
        send_cost(1'b0, 0, 65535, 255);
        send_cost(1'b0, 1, 65535, 255);
        send_cost(1'b0, 2, 65535, 255);
        send_cost(1'b0, 3, 65535, 255);
        // Equal intensity again, zero costs.
        send_cost(1'b0, 0, 0, 255);
        send_cost(1'b0, 1, 0, 255);
        send_cost(1'b0, 2, 0, 255);
        send_cost(1'b0, 3, 0, 255);
        // Disparities outside the count in use.
        send_cost(1'b1, 4, 65535, 0);
        send_cost(1'b1, 127, 65535, 170);
        // A skipped disparity leaves the left neighbour stale.
        send_cost(1'b0, 0, 500, 128);
        send_cost(1'b0, 2, 7, 128);
        send_cost(1'b0, 3, 3000, 128);
        // Disordered disparities.
        send_cost(1'b0, 0, 20, 128);
        send_cost(1'b0, 3, 0, 128);
        send_cost(1'b0, 1, 65535, 128);
        send_cost(1'b0, 2, 100, 128);
        // A new path.
        send_cost(1'b1, 0, 9, 64);
        send_cost(1'b0, 1, 10, 64);
        send_cost(1'b0, 2, 11, 64);
        send_cost(1'b0, 3, 12, 64);

        for (phase = 0; sent_in_range < ITEM_TARGET; phase++) begin
            case ($urandom_range(0, 3))
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 15;
                2: sender_idle_pct = 40;
                default: sender_idle_pct = 70;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 10;
                2: stall_pct = 30;
                default: stall_pct = 60;
            endcase
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                    configure(CFG_DATA_W'(NEAR_RESET), FAR_RESET,
                              CFG_DATA_W'(DCNT_RESET), 1'b1);
                end
                1: configure(16'd0, 16'd0, 16'd1, 1'b0);
                2: begin
                    sender_idle_pct = 0;
                    configure(16'd1023, 16'hFFFF, 16'd128, 1'b0);
                end
                3: configure(16'd1023, 16'd200, 16'd16, 1'b0);
                4: configure(16'hFC05, 16'hFFFF, 16'd0, 1'b0);
                5: configure(16'd30, 16'd38250, 16'hFF81, 1'b0);
                6: configure(16'd2, 16'd1, 16'd255, 1'b0);
                default: begin
                    near_data = CFG_DATA_W'($urandom_range(0, 1023));
                    if ($urandom_range(0, 3) == 0) near_data[15:10] = 6'($urandom_range(0, 63));
                    if ($urandom_range(0, 3) == 0) begin
                        far_data = CFG_DATA_W'($urandom_range(0, 300));
                    end else begin
                        far_data = CFG_DATA_W'($urandom_range(0, 65535));
                    end
                    if ($urandom_range(0, 99) < 70) begin
                        count_data = CFG_DATA_W'($urandom_range(1, 16));
                    end else if ($urandom_range(0, 1) == 0) begin
                        count_data = CFG_DATA_W'($urandom_range(17, 64));
                    end else begin
                        count_data = CFG_DATA_W'($urandom_range(65, 255));
                    end
                    configure(near_data, far_data, count_data, 1'b0);
                end
            endcase
            // The receiver holds off while the sender keeps offering items.
            if (phase == 2) long_hold_pending = 1'b1;
            run_phase(PHASE_ITEMS);
        end

        drain_results(1'b1);
        if (error_count == 0) begin
            $display("sgm_path_cost_step_tb: PASS");
        end else begin
            $display("sgm_path_cost_step_tb: FAIL");
        end
        $finish;
    end

endmodule

### sgm_path_cost_step.f
rtl/sgm_pcs_pkg.sv
rtl/sgm_pcs_div.sv
rtl/sgm_pcs_row_mem.sv
rtl/sgm_path_cost_step.sv
dv/sgm_path_cost_step_checker.sv
dv/sgm_path_cost_step_tb.sv
